// ===== src/smm_pkg.sv =====
`default_nettype none
package smm_pkg;

  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 8;
  localparam int REG_W      = 5;
  localparam int SLOT_W     = 5;
  localparam int BANK_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int SHIFT_LEN  = 5;

  localparam logic [7:0]        BANKS_RST    = 8'd16;
  localparam logic [7:0]        BANKS_1024K  = 8'd128;
  localparam logic [7:0]        BANKS_512K   = 8'd64;
  localparam logic [REG_W-1:0]  CONTROL_RST  = 5'h0C;
  localparam logic [BANK_W-1:0] CHR_HIGH_RST = 7'd4;

  // target register of a completed serial load, selected by address bits 14:13
  typedef enum logic [1:0] {
    REG_CONTROL = 2'd0,
    REG_CHR_A   = 2'd1,
    REG_CHR_B   = 2'd2,
    REG_PRG     = 2'd3
  } reg_sel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRG_BANKS = 2'd0,
    CFG_CHR_ROM   = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic             load;
    reg_sel_t         num;
    logic [REG_W-1:0] value;
  } reg_load_t;

  typedef struct packed {
    logic [BANK_W-1:0] prg_bank_8000;
    logic [BANK_W-1:0] prg_bank_a000;
    logic [BANK_W-1:0] prg_bank_c000;
    logic [BANK_W-1:0] prg_bank_e000;
    logic [1:0]        mirroring;
    logic [BANK_W-1:0] chr_low_base;
    logic [BANK_W-1:0] chr_high_base;
  } map_t;

endpackage
`default_nettype wire

// ===== src/smm_in_if.sv =====
`default_nettype none
interface smm_in_if;
  logic                        valid;
  logic                        ready;
  logic [smm_pkg::ADDR_W-1:0]  address;
  logic [smm_pkg::DATA_W-1:0]  write_data;

  modport source (output valid, output address, output write_data, input ready);
  modport sink   (input valid, input address, input write_data, output ready);
endinterface
`default_nettype wire

// ===== src/smm_out_if.sv =====
`default_nettype none
interface smm_out_if;
  logic                        valid;
  logic                        ready;
  logic [smm_pkg::BANK_W-1:0]  prg_bank_8000;
  logic [smm_pkg::BANK_W-1:0]  prg_bank_a000;
  logic [smm_pkg::BANK_W-1:0]  prg_bank_c000;
  logic [smm_pkg::BANK_W-1:0]  prg_bank_e000;
  logic [1:0]                  mirroring;
  logic [smm_pkg::BANK_W-1:0]  chr_low_base;
  logic [smm_pkg::BANK_W-1:0]  chr_high_base;

  modport source (output valid, output prg_bank_8000, output prg_bank_a000,
                  output prg_bank_c000, output prg_bank_e000, output mirroring,
                  output chr_low_base, output chr_high_base, input ready);
  modport sink   (input valid, input prg_bank_8000, input prg_bank_a000,
                  input prg_bank_c000, input prg_bank_e000, input mirroring,
                  input chr_low_base, input chr_high_base, output ready);
endinterface
`default_nettype wire

// ===== src/smm_cfg_if.sv =====
`default_nettype none
interface smm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [smm_pkg::CFG_IDX_W-1:0]   index;
  logic [smm_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== src/smm_shift.sv =====
`default_nettype none
module smm_shift (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [smm_pkg::ADDR_W-1:0]  address,
  input  logic [smm_pkg::DATA_W-1:0]  write_data,
  output smm_pkg::reg_load_t          ld
);
  import smm_pkg::*;

  logic [REG_W-1:0] shift_value_r, shift_value_nxt;
  logic [2:0]       shift_count_r, shift_count_nxt;
  logic [1:0]       last_region_r, last_region_nxt;

  logic [1:0]       region;
  logic [REG_W-1:0] sv;
  logic [REG_W-1:0] sv_bit;
  logic [2:0]       sc;

  always_comb begin
    region          = address[14:13];
    sv              = shift_value_r;
    sc              = shift_count_r;
    sv_bit          = '0;
    shift_value_nxt = shift_value_r;
    shift_count_nxt = shift_count_r;
    last_region_nxt = last_region_r;
    ld              = '{load: 1'b0, num: REG_CONTROL, value: '0};
    if (address[15]) begin
      if (region != last_region_r) begin
        sv = '0;
        sc = '0;
      end
      last_region_nxt = region;
      if (write_data[7]) begin
        shift_value_nxt = '0;
        shift_count_nxt = '0;
      end else begin
        sv_bit = sv | (REG_W'(write_data[0]) << sc);
        if (sc == 3'(SHIFT_LEN - 1)) begin
          ld.load         = 1'b1;
          ld.num          = reg_sel_t'(region);
          ld.value        = sv_bit;
          shift_value_nxt = '0;
          shift_count_nxt = '0;
        end else begin
          shift_value_nxt = sv_bit;
          shift_count_nxt = sc + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_value_r <= '0;
      shift_count_r <= '0;
      last_region_r <= '0;
    end else if (step) begin
      shift_value_r <= shift_value_nxt;
      shift_count_r <= shift_count_nxt;
      last_region_r <= last_region_nxt;
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    shift_count_r < 3'(SHIFT_LEN))
    else $error("shift count out of range");

  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && ld.load |=> shift_count_r == 3'd0 && shift_value_r == '0)
    else $error("shift not cleared after register load");
`endif
endmodule
`default_nettype wire

// ===== src/smm_regs.sv =====
`default_nettype none
module smm_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  smm_pkg::reg_load_t             ld,
  input  logic                           cfg_we,
  input  logic [smm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [smm_pkg::CFG_DATA_W-1:0] cfg_data,
  output smm_pkg::map_t                  map_nxt
);
  import smm_pkg::*;

  function automatic logic [SLOT_W-1:0] high_bank(input logic [7:0] banks, input logic k);
    logic             small_rom;
    logic [SLOT_W-1:0] res;
    small_rom = (banks != BANKS_1024K) && (banks != BANKS_512K);
    if (small_rom) begin
      res = SLOT_W'(banks - 8'd2 + {7'd0, k});
    end else begin
      res = SLOT_W'(5'd30 + {4'd0, k});
    end
    return res;
  endfunction

  logic [7:0]        banks_r, banks_nxt;
  logic              chr_rom_r, chr_rom_nxt;
  logic [REG_W-1:0]  control_r, control_nxt;
  logic              chr_a_hi_r, chr_a_hi_nxt;
  logic              chr_b_hi_r, chr_b_hi_nxt;
  logic [1:0]        outer_r, outer_nxt;
  logic              swap_r, swap_nxt;
  logic [SLOT_W-1:0] slot_r   [4];
  logic [SLOT_W-1:0] slot_nxt [4];
  logic [BANK_W-1:0] chr_low_r, chr_low_nxt;
  logic [BANK_W-1:0] chr_high_r, chr_high_nxt;

  logic              is_1024k;
  logic              is_512k;
  logic              is_small;
  logic              mode4k;
  logic              mode16k;
  logic [SLOT_W-1:0] b;
  logic [BANK_W-1:0] chr_base;

  always_comb begin
    is_1024k = banks_r == BANKS_1024K;
    is_512k  = banks_r == BANKS_512K;
    is_small = !is_1024k && !is_512k;
    mode4k   = control_r[4];
    mode16k  = control_r[3];
    b        = {ld.value[3:0], 1'b0};
    chr_base = {ld.value, 2'b00};

    banks_nxt    = banks_r;
    chr_rom_nxt  = chr_rom_r;
    control_nxt  = control_r;
    chr_a_hi_nxt = chr_a_hi_r;
    chr_b_hi_nxt = chr_b_hi_r;
    outer_nxt    = outer_r;
    swap_nxt     = swap_r;
    slot_nxt     = slot_r;
    chr_low_nxt  = chr_low_r;
    chr_high_nxt = chr_high_r;

    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PRG_BANKS: begin
          banks_nxt   = cfg_data;
          slot_nxt[0] = 5'd0;
          slot_nxt[1] = 5'd1;
          slot_nxt[2] = high_bank(cfg_data, 1'b0);
          slot_nxt[3] = high_bank(cfg_data, 1'b1);
          outer_nxt   = 2'd0;
          swap_nxt    = 1'b0;
        end
        CFG_CHR_ROM: begin
          chr_rom_nxt = cfg_data[0];
        end
        default: begin
        end
      endcase
    end else if (step && ld.load) begin
      case (ld.num)
        REG_CONTROL: begin
          control_nxt = ld.value;
        end
        REG_CHR_A: begin
          chr_a_hi_nxt = ld.value[4];
          if (is_1024k) begin
            if (mode4k) begin
              if (swap_r) begin
                outer_nxt = {mode16k & chr_b_hi_r, ld.value[4]};
                swap_nxt  = 1'b0;
              end else begin
                swap_nxt = 1'b1;
              end
            end else begin
              outer_nxt = {2{ld.value[4]}};
            end
          end else if (is_512k && !chr_rom_r) begin
            outer_nxt = {1'b0, ld.value[4]};
          end else if (chr_rom_r) begin
            chr_low_nxt = chr_base;
            if (!mode4k) begin
              chr_high_nxt = chr_base + 7'd4;
            end
          end else if (mode4k) begin
            chr_low_nxt = chr_base;
          end
        end
        REG_CHR_B: begin
          chr_b_hi_nxt = ld.value[4];
          if (is_1024k && mode16k) begin
            if (swap_r) begin
              outer_nxt = {ld.value[4], chr_a_hi_r};
              swap_nxt  = 1'b0;
            end else begin
              swap_nxt = 1'b1;
            end
          end
          if (mode4k) begin
            chr_high_nxt = chr_base;
          end
        end
        REG_PRG: begin
          if (mode16k) begin
            if (control_r[2]) begin
              slot_nxt[0] = b;
              slot_nxt[1] = b + 5'd1;
              slot_nxt[2] = high_bank(banks_r, 1'b0);
              slot_nxt[3] = high_bank(banks_r, 1'b1);
            end else if (is_small) begin
              slot_nxt[0] = 5'd0;
              slot_nxt[1] = 5'd1;
              slot_nxt[2] = b;
              slot_nxt[3] = b + 5'd1;
            end
          end else begin
            slot_nxt[0] = b;
            slot_nxt[1] = b + 5'd1;
            if (is_small) begin
              slot_nxt[2] = b + 5'd2;
              slot_nxt[3] = b + 5'd3;
            end
          end
        end
        default: begin
        end
      endcase
    end

    map_nxt.prg_bank_8000 = {outer_nxt, slot_nxt[0]};
    map_nxt.prg_bank_a000 = {outer_nxt, slot_nxt[1]};
    map_nxt.prg_bank_c000 = {outer_nxt, slot_nxt[2]};
    map_nxt.prg_bank_e000 = {outer_nxt, slot_nxt[3]};
    map_nxt.mirroring     = control_nxt[1:0];
    map_nxt.chr_low_base  = chr_low_nxt;
    map_nxt.chr_high_base = chr_high_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      banks_r    <= BANKS_RST;
      chr_rom_r  <= 1'b1;
      control_r  <= CONTROL_RST;
      chr_a_hi_r <= 1'b0;
      chr_b_hi_r <= 1'b0;
      outer_r    <= 2'd0;
      swap_r     <= 1'b0;
      slot_r[0]  <= 5'd0;
      slot_r[1]  <= 5'd1;
      slot_r[2]  <= high_bank(BANKS_RST, 1'b0);
      slot_r[3]  <= high_bank(BANKS_RST, 1'b1);
      chr_low_r  <= '0;
      chr_high_r <= CHR_HIGH_RST;
    end else begin
      banks_r    <= banks_nxt;
      chr_rom_r  <= chr_rom_nxt;
      control_r  <= control_nxt;
      chr_a_hi_r <= chr_a_hi_nxt;
      chr_b_hi_r <= chr_b_hi_nxt;
      outer_r    <= outer_nxt;
      swap_r     <= swap_nxt;
      slot_r     <= slot_nxt;
      chr_low_r  <= chr_low_nxt;
      chr_high_r <= chr_high_nxt;
    end
  end

`ifndef SYNTH
  a_size_write_inits: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index == CFG_PRG_BANKS
    |=> slot_r[0] == 5'd0 && slot_r[1] == 5'd1 && outer_r == 2'd0 && !swap_r)
    else $error("program slots not reinitialized on size write");

  a_swap_only_1024k: assert property (@(posedge clk) disable iff (!rst_n)
    !is_1024k && !swap_r |=> !swap_r)
    else $error("swap pending set outside 1024K class");
`endif
endmodule
`default_nettype wire

// ===== src/serial_bank_mapper_unit.sv =====
// Serial bank mapper.
// in_ch carries CPU writes (address, write_data). Writes below 0x8000 leave
// the mapping alone; others feed the five-bit serial loader, and every
// fifth bit loads the control, CHR or PRG register picked by address bits
// 14:13. Every accepted item yields exactly one item on out_ch: the four 8K
// PRG banks, mirroring and the two CHR 1K bases after that write.
// cfg_ch writes the size registers (index 0: 8K PRG bank count, index 1:
// CHR ROM present); it is always ready and is meant for idle periods.
// out_ch.valid rises after the item has passed the input register and then
// the result register; throughput is one item per cycle while out_ch does
// not stall.
// Reset (rst_n low, synchronous) empties both stages, clears the serial
// loader and loads control 0x0C, CHR bases 0 and 4, 16 banks with CHR ROM.
// When out_ch stalls, one more item is taken into the input register and
// in_ch.ready then drops until the result is taken.
`default_nettype none
module serial_bank_mapper_unit (
  input  logic       clk,
  input  logic       rst_n,
  smm_in_if.sink     in_ch,
  smm_out_if.source  out_ch,
  smm_cfg_if.sink    cfg_ch
);
  import smm_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [DATA_W-1:0] s1_data_r;
  logic              out_valid_r, out_valid_nxt;
  map_t              out_map_r;
  map_t              map_nxt;
  reg_load_t         ld;
  logic              adv;
  logic              step;
  logic              in_fire;

  assign adv     = !out_valid_r || out_ch.ready;
  assign step    = s1_valid_r && adv;
  assign in_fire = in_ch.valid && in_ch.ready;

  assign in_ch.ready  = !s1_valid_r || adv;
  assign cfg_ch.ready = 1'b1;

  smm_shift u_shift (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .address    (s1_addr_r),
    .write_data (s1_data_r),
    .ld         (ld)
  );

  smm_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .ld        (ld),
    .cfg_we    (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .map_nxt   (map_nxt)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_addr_r <= in_ch.address;
      s1_data_r <= in_ch.write_data;
    end
    if (step) begin
      out_map_r <= map_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.prg_bank_8000 = out_map_r.prg_bank_8000;
  assign out_ch.prg_bank_a000 = out_map_r.prg_bank_a000;
  assign out_ch.prg_bank_c000 = out_map_r.prg_bank_c000;
  assign out_ch.prg_bank_e000 = out_map_r.prg_bank_e000;
  assign out_ch.mirroring     = out_map_r.mirroring;
  assign out_ch.chr_low_base  = out_map_r.chr_low_base;
  assign out_ch.chr_high_base = out_map_r.chr_high_base;

`ifndef SYNTH
  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted with both stages full");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted item lost from input register");
`endif
endmodule
`default_nettype wire
